[design/rgbc_pkg.sv]
// Shared types and constants for the RGB 3x3 convolution block.
package rgbc_pkg;

	localparam int TAPS    = 9;
	localparam int PIX_W   = 24;
	localparam int COEF_W  = 16;
	localparam int SUM_W   = 32;
	localparam int MAG_W   = 27;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int PIX_MAX = 255;
	localparam int KERNEL_SIZE = 3;

	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_KTOP   = 3'd2;
	localparam logic [2:0] CFG_KMID   = 3'd3;
	localparam logic [2:0] CFG_KBOT   = 3'd4;
	localparam logic [2:0] CFG_DIV    = 3'd5;

	typedef struct packed {
		logic [10:0] width;
		logic [12:0] height;
	} rgbc_dim_t;

	typedef struct packed {
		logic [TAPS-1:0][COEF_W-1:0] k;
		logic [COEF_W-1:0]           div;
	} rgbc_coef_t;

	typedef struct packed {
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic                       last;
		logic [TAPS-1:0][PIX_W-1:0] win;
	} rgbc_job_t;

endpackage

[design/rgbc_if.sv]
// Stream and configuration channel interfaces.
interface rgbc_pix_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source(output valid, frame_start, in_red, in_green, in_blue, input ready);
	modport sink(input valid, frame_start, in_red, in_green, in_blue, output ready);
endinterface

interface rgbc_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        frame_last;
	modport source(output valid, out_row, out_col, out_red, out_green, out_blue,
		frame_last, input ready);
	modport sink(input valid, out_row, out_col, out_red, out_green, out_blue,
		frame_last, output ready);
endinterface

interface rgbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/rgbc_front.sv]
// Front end: position counters, line buffers, window and job issue.
module rgbc_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	rgbc_pix_if.sink            pix_in,
	input  rgbc_pkg::rgbc_dim_t dim,
	output logic                push_valid,
	input  logic                push_ready,
	output rgbc_pkg::rgbc_job_t push_job
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	typedef enum logic [1:0] {F_IDLE, F_UPD, F_PUSH} fstate_t;

	fstate_t state_q;
	logic [CW-1:0] col_q, c_s1, c0;
	logic [RW-1:0] row_q, r_s1, r0;
	logic [rgbc_pkg::PIX_W-1:0] pix_s1, older_rd_s1, newer_rd_s1;
	logic [rgbc_pkg::TAPS-1:0][rgbc_pkg::PIX_W-1:0] win_q;
	logic [rgbc_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [rgbc_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];
	int w, h;
	logic accept, interior;

	// clamp the configured frame size
	always_comb begin
		w = 32'(dim.width);
		h = 32'(dim.height);
		if (w < rgbc_pkg::KERNEL_SIZE) w = rgbc_pkg::KERNEL_SIZE;
		else if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < rgbc_pkg::KERNEL_SIZE) h = rgbc_pkg::KERNEL_SIZE;
		else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
	end

	assign pix_in.ready = (state_q == F_IDLE);
	assign accept = pix_in.valid && pix_in.ready;

	// position of the incoming pixel
	always_comb begin
		c0 = pix_in.frame_start ? '0 : col_q;
		r0 = pix_in.frame_start ? '0 : row_q;
		if (32'(c0) >= w) c0 = '0;
		if (32'(r0) >= h) r0 = '0;
	end

	assign interior = (32'(r_s1) >= 2) && (32'(c_s1) >= 2);

	// line buffers: read on transfer, write back in the F_UPD state that follows
	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_s1 <= older_mem[c0];
			newer_rd_s1 <= newer_mem[c0];
			pix_s1      <= {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
			r_s1        <= r0;
			c_s1        <= c0;
		end
		if (state_q == F_UPD) begin
			older_mem[c_s1] <= newer_rd_s1;
			newer_mem[c_s1] <= pix_s1;
		end
	end

	// sequence, window and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			win_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_UPD;
				end
				F_UPD: begin
					for (int i = 0; i < rgbc_pkg::KERNEL_SIZE; i++) begin
						win_q[i*3]   <= win_q[i*3+1];
						win_q[i*3+1] <= win_q[i*3+2];
					end
					win_q[2] <= older_rd_s1;
					win_q[5] <= newer_rd_s1;
					win_q[8] <= pix_s1;
					if (32'(c_s1) + 1 >= w) begin
						col_q <= '0;
						row_q <= (32'(r_s1) + 1 >= h) ? '0 : RW'(32'(r_s1) + 1);
					end else begin
						col_q <= CW'(32'(c_s1) + 1);
						row_q <= r_s1;
					end
					state_q <= interior ? F_PUSH : F_IDLE;
				end
				F_PUSH: begin
					if (push_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// job for the back end
	always_comb begin
		push_job.row  = rgbc_pkg::ROW_W'(32'(r_s1) - 1);
		push_job.col  = rgbc_pkg::COL_W'(32'(c_s1) - 1);
		push_job.last = (32'(r_s1) == h - 1) && (32'(c_s1) == w - 1);
		push_job.win  = win_q;
	end

	assign push_valid = (state_q == F_PUSH);

endmodule

[design/rgbc_queue.sv]
// Two-entry job queue between front and back end.
module rgbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rgbc_pkg::rgbc_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rgbc_pkg::rgbc_job_t pop_job
);

	rgbc_pkg::rgbc_job_t entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = entry_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_q] <= push_job;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

[design/rgbc_back.sv]
// Back end: serial multiply-accumulate, restoring divide and clamp.
module rgbc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  rgbc_pkg::rgbc_job_t  pop_job,
	input  rgbc_pkg::rgbc_coef_t coef,
	rgbc_res_if.source           res_out
);

	typedef enum logic [1:0] {B_IDLE, B_MAC, B_DIV, B_OUT} bstate_t;

	bstate_t state_q;
	rgbc_pkg::rgbc_job_t job_q;
	logic [3:0] tap_q;
	logic [4:0] step_q;
	logic signed [rgbc_pkg::SUM_W-1:0] acc_q [3];
	logic [rgbc_pkg::MAG_W-1:0]  num_q [3];
	logic [rgbc_pkg::COEF_W-1:0] rem_q [3];
	logic [rgbc_pkg::COEF_W-1:0] dv;
	logic [rgbc_pkg::COEF_W:0]   trial [3];
	logic signed [rgbc_pkg::SUM_W-1:0] prod [3];
	logic [rgbc_pkg::PIX_W-1:0]  sample;
	logic [rgbc_pkg::COEF_W-1:0] k;

	assign dv        = (coef.div == '0) ? rgbc_pkg::COEF_W'(1) : coef.div;
	assign pop_ready = (state_q == B_IDLE);
	assign sample    = job_q.win[tap_q];
	assign k         = coef.k[tap_q];

	// one tap product per plane, and one divide step per plane
	always_comb begin
		for (int p = 0; p < 3; p++) begin
			prod[p]  = rgbc_pkg::SUM_W'($signed({1'b0, sample[p*8 +: 8]}) * $signed(k));
			trial[p] = {rem_q[p], num_q[p][rgbc_pkg::MAG_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			res_out.valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						job_q   <= pop_job;
						tap_q   <= '0;
						for (int p = 0; p < 3; p++) acc_q[p] <= '0;
						state_q <= B_MAC;
					end
				end
				B_MAC: begin
					for (int p = 0; p < 3; p++) acc_q[p] <= acc_q[p] + prod[p];
					if (tap_q == 4'(rgbc_pkg::TAPS - 1)) begin
						state_q <= B_DIV;
						step_q  <= '0;
						for (int p = 0; p < 3; p++) begin
							num_q[p] <= '0;
							rem_q[p] <= '0;
						end
					end
					tap_q <= tap_q + 4'd1;
				end
				B_DIV: begin
					// first step loads the magnitude; a sum at or below zero clamps to zero
					if (step_q == '0 && tap_q != '0) begin
						for (int p = 0; p < 3; p++)
							num_q[p] <= (acc_q[p] > 0) ? rgbc_pkg::MAG_W'(acc_q[p]) : '0;
						tap_q <= '0;
					end else begin
						for (int p = 0; p < 3; p++) begin
							if (trial[p] >= {1'b0, dv}) begin
								rem_q[p] <= rgbc_pkg::COEF_W'(trial[p] - {1'b0, dv});
								num_q[p] <= {num_q[p][rgbc_pkg::MAG_W-2:0], 1'b1};
							end else begin
								rem_q[p] <= trial[p][rgbc_pkg::COEF_W-1:0];
								num_q[p] <= {num_q[p][rgbc_pkg::MAG_W-2:0], 1'b0};
							end
						end
						if (step_q == 5'(rgbc_pkg::MAG_W - 1)) state_q <= B_OUT;
						step_q <= step_q + 5'd1;
					end
				end
				B_OUT: begin
					if (!res_out.valid) begin
						res_out.valid      <= 1'b1;
						res_out.out_row    <= job_q.row;
						res_out.out_col    <= job_q.col;
						res_out.frame_last <= job_q.last;
						res_out.out_red    <= (num_q[0] > rgbc_pkg::PIX_MAX) ? 8'hFF : num_q[0][7:0];
						res_out.out_green  <= (num_q[1] > rgbc_pkg::PIX_MAX) ? 8'hFF : num_q[1][7:0];
						res_out.out_blue   <= (num_q[2] > rgbc_pkg::PIX_MAX) ? 8'hFF : num_q[2][7:0];
					end else if (res_out.ready) begin
						res_out.valid <= 1'b0;
						state_q       <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

[design/rgb_3x3_convolution_clamp.sv]
// Top level: configuration registers and the front, queue and back end.
// Front end takes one pixel at a time and passes through F_UPD, and F_PUSH when it issues
// a filter job, before it is ready again. Back end takes a job, multiply-accumulates the
// nine taps, runs the restoring divide and presents the result, so interior pixels are
// paced by the serial divider; it takes a new job only once the last result is taken.
// Reset clears counters, window and handshake state; line buffers are not cleared.
module rgb_3x3_convolution_clamp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	rgbc_pix_if.sink    pix_in,
	rgbc_res_if.source  res_out,
	rgbc_cfg_if.sink    cfg
);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [47:0] krow_q [3];
	logic [15:0] div_q;
	rgbc_pkg::rgbc_dim_t  dim;
	rgbc_pkg::rgbc_coef_t coef;
	rgbc_pkg::rgbc_job_t  push_job, pop_job;
	logic push_valid, push_ready, pop_valid, pop_ready;

	assign cfg.ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd1024;
			height_q  <= 13'd4096;
			krow_q[0] <= 48'd0;
			krow_q[1] <= 48'd65536;
			krow_q[2] <= 48'd0;
			div_q     <= 16'd1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rgbc_pkg::CFG_WIDTH:  width_q   <= cfg.data[10:0];
				rgbc_pkg::CFG_HEIGHT: height_q  <= cfg.data[12:0];
				rgbc_pkg::CFG_KTOP:   krow_q[0] <= cfg.data;
				rgbc_pkg::CFG_KMID:   krow_q[1] <= cfg.data;
				rgbc_pkg::CFG_KBOT:   krow_q[2] <= cfg.data;
				rgbc_pkg::CFG_DIV:    div_q     <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dim.width  = width_q;
		dim.height = height_q;
		coef.div   = div_q;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				coef.k[i*3+j] = krow_q[i][16*j +: 16];
	end

	rgbc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .pix_in, .dim,
		.push_valid, .push_ready, .push_job
	);

	rgbc_queue u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_job,
		.pop_valid, .pop_ready, .pop_job
	);

	rgbc_back u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_job, .coef, .res_out
	);

	// front end drops its ready for the cycle after a transfer
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> !pix_in.ready)
		else $error("front accepted back-to-back pixels");

	// a stalled job is held until the queue takes it
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid && $stable(push_job))
		else $error("job dropped while queue full");

	// back end is busy after taking a job
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready |=> !pop_ready)
		else $error("back end took two jobs at once");

endmodule

[sim/rgbc_conv_checker.sv]
`timescale 1ns / 1ps
// Checker for the RGB 3x3 convolution block: tracks the stream, predicts and compares results.
module rgbc_conv_checker (
	input  logic  clk,
	input  logic  arst_n,
	rgbc_pix_if   pix,
	rgbc_res_if   res,
	rgbc_cfg_if   cfg,
	output int    fails,
	output int    pending
);

	typedef struct {
		logic [rgbc_pkg::ROW_W-1:0] row;
		logic [rgbc_pkg::COL_W-1:0] col;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} filtered_px_t;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;

	// Shadow of the configuration registers
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic [47:0] kernel_reg [rgbc_pkg::KERNEL_SIZE];
	logic [15:0] div_reg;

	// Shadow of the datapath state
	logic [rgbc_pkg::PIX_W-1:0] older_line [MAX_W];
	logic [rgbc_pkg::PIX_W-1:0] newer_line [MAX_W];
	logic [rgbc_pkg::PIX_W-1:0] window [rgbc_pkg::KERNEL_SIZE][rgbc_pkg::KERNEL_SIZE];
	int unsigned      row_pos;
	int unsigned      col_pos;

	filtered_px_t filtered_q [$];

	function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Weighted sum of one plane, divided toward zero and clamped to a sample
	function automatic logic [7:0] filter_plane(int shift);
		int                 acc;
		int                 dv;
		int                 sample;
		logic signed [15:0] k;
		acc = 0;
		dv = (div_reg == 0) ? 1 : int'(div_reg);
		for (int i = 0; i < rgbc_pkg::KERNEL_SIZE; i++)
			for (int j = 0; j < rgbc_pkg::KERNEL_SIZE; j++) begin
				k = kernel_reg[i][16*j +: 16];
				sample = int'(window[i][j][shift +: 8]);
				acc += sample * int'(k);
			end
		acc = acc / dv;
		if (acc < 0)
			acc = 0;
		else if (acc > rgbc_pkg::PIX_MAX)
			acc = rgbc_pkg::PIX_MAX;
		return acc[7:0];
	endfunction

	// Advance the shadow state by one accepted pixel, queueing any filtered result
	task automatic take_pixel(logic fs, logic [rgbc_pkg::PIX_W-1:0] px);
		int unsigned  w;
		int unsigned  h;
		int unsigned  r;
		int unsigned  c;
		filtered_px_t e;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		if (fs) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		for (int i = 0; i < rgbc_pkg::KERNEL_SIZE; i++) begin
			window[i][0] = window[i][1];
			window[i][1] = window[i][2];
		end
		window[0][2] = older_line[c];
		window[1][2] = newer_line[c];
		window[2][2] = px;
		older_line[c] = newer_line[c];
		newer_line[c] = px;
		if (r >= 2 && c >= 2) begin
			e.row   = rgbc_pkg::ROW_W'(r - 1);
			e.col   = rgbc_pkg::COL_W'(c - 1);
			e.red   = filter_plane(0);
			e.green = filter_plane(8);
			e.blue  = filter_plane(16);
			e.last  = (r == h - 1) && (c == w - 1);
			filtered_q.push_back(e);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_px_t e;
		if (!arst_n) begin
			width_reg  = 11'd1024;
			height_reg = 13'd4096;
			kernel_reg[0] = 48'd0;
			kernel_reg[1] = 48'd65536;
			kernel_reg[2] = 48'd0;
			div_reg    = 16'd1;
			for (int i = 0; i < rgbc_pkg::KERNEL_SIZE; i++)
				for (int j = 0; j < rgbc_pkg::KERNEL_SIZE; j++)
					window[i][j] = '0;
			row_pos = 0;
			col_pos = 0;
			filtered_q.delete();
			pending <= 0;
		end else begin
			// Register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					rgbc_pkg::CFG_WIDTH:  width_reg  = cfg.data[10:0];
					rgbc_pkg::CFG_HEIGHT: height_reg = cfg.data[12:0];
					rgbc_pkg::CFG_KTOP:   kernel_reg[0] = cfg.data;
					rgbc_pkg::CFG_KMID:   kernel_reg[1] = cfg.data;
					rgbc_pkg::CFG_KBOT:   kernel_reg[2] = cfg.data;
					rgbc_pkg::CFG_DIV:    div_reg    = cfg.data[15:0];
					default: ;
				endcase
			end
			// Pixel transfers
			if (pix.valid && pix.ready)
				take_pixel(pix.frame_start, {pix.in_blue, pix.in_green, pix.in_red});
			// Result transfers
			if (res.valid && res.ready) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result at row %0d col %0d", res.out_row, res.out_col);
					fails++;
				end else begin
					e = filtered_q.pop_front();
					compare_field("out_row", e.row, res.out_row);
					compare_field("out_col", e.col, res.out_col);
					compare_field("out_red", e.red, res.out_red);
					compare_field("out_green", e.green, res.out_green);
					compare_field("out_blue", e.blue, res.out_blue);
					compare_field("frame_last", e.last, res.frame_last);
				end
			end
			pending <= filtered_q.size();
		end
	end

endmodule

[sim/tb_rgb_3x3_convolution_clamp.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, pixel and register stimulus, and the verdict.
module tb_rgb_3x3_convolution_clamp;

	localparam int LIMIT       = 3000000;
	localparam int SETTLE      = 80;
	localparam int RAND_ITEMS  = 950;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles;
	int   items;
	bit   quiet;
	int   rx_hold;

	rgbc_pix_if pix ();
	rgbc_res_if res ();
	rgbc_cfg_if cfg ();

	rgb_3x3_convolution_clamp u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix),
		.res_out (res),
		.cfg     (cfg)
	);

	rgbc_conv_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res     (res),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls per result, with an occasional long hold-off
	initial begin
		int n;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = quiet ? 0 : $urandom_range(17, 0);
			end
			if (n > 0) begin
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [15:0] rand_coef();
		int unsigned pick;
		pick = $urandom_range(9, 0);
		if (pick < 5)
			return 16'($urandom_range(8, 0) - 4);
		if (pick < 8)
			return 16'($urandom);
		return (pick == 8) ? 16'h7FFF : 16'h8000;
	endfunction

	function automatic logic [47:0] rand_kernel_row();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [15:0] rand_divisor();
		int unsigned pick;
		pick = $urandom_range(9, 0);
		if (pick == 0)
			return 16'd0;
		if (pick == 1)
			return 16'hFFFF;
		if (pick == 2)
			return 16'($urandom);
		return 16'($urandom_range(24, 1));
	endfunction

	function automatic logic [7:0] rand_sample();
		int unsigned pick;
		pick = $urandom_range(7, 0);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Write every register in one burst; valid stays high across the burst
	task automatic set_config(logic [10:0] w, logic [12:0] h, logic [47:0] kt,
		logic [47:0] km, logic [47:0] kb, logic [15:0] dv);
		logic [47:0] vals [6];
		logic [2:0]  idx  [6];
		vals = '{48'(w), 48'(h), kt, km, kb, 48'(dv)};
		idx  = '{rgbc_pkg::CFG_WIDTH, rgbc_pkg::CFG_HEIGHT, rgbc_pkg::CFG_KTOP,
			rgbc_pkg::CFG_KMID, rgbc_pkg::CFG_KBOT, rgbc_pkg::CFG_DIV};
		for (int i = 0; i < 6; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data  <= vals[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	// Offer one pixel after a random gap and hold it until transfer
	task automatic send_pixel(logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(17, 0);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.frame_start <= fs;
		pix.in_red      <= r;
		pix.in_green    <= g;
		pix.in_blue     <= b;
		do @(posedge clk); while (!pix.ready);
		items++;
	endtask

	// Send count pixels of a frame; the first carries fs, with rare restarts as noise
	task automatic send_frame(int unsigned count, logic fs);
		logic f;
		for (int unsigned i = 0; i < count; i++) begin
			f = (i == 0) ? fs : ($urandom_range(99, 0) == 0);
			send_pixel(f, rand_sample(), rand_sample(), rand_sample());
		end
	endtask

	// Stop offering, wait for every expected result, then let the pipeline settle
	task automatic drain();
		pix.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int unsigned wr;
		int unsigned hr;
		int unsigned w;
		int unsigned h;
		int unsigned nfr;
		int unsigned pick;
		arst_n          = 1'b0;
		items           = 0;
		quiet           = 1'b0;
		rx_hold         = 0;
		pix.valid       <= 1'b0;
		pix.frame_start <= 1'b0;
		pix.in_red      <= '0;
		pix.in_green    <= '0;
		pix.in_blue     <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= rgbc_pkg::CFG_WIDTH;
		cfg.data        <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Box blur over a 4x3 frame of black and white
		set_config(11'd4, 13'd3, {3{16'd1}}, {3{16'd1}}, {3{16'd1}}, 16'd9);
		for (int i = 0; i < 12; i++)
			send_pixel(i == 0, (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'hFF : 8'h00,
				(i > 5) ? 8'hFF : 8'h00);
		drain();

		// Undersized width and height, zero divisor, extreme coefficients
		set_config(11'd0, 13'd2, {16'h7FFF, 16'h8000, 16'h7FFF},
			{16'hFFFF, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'hFFFF, 16'h0000}, 16'd0);
		for (int i = 0; i < 9; i++)
			send_pixel(i == 0, (i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'h00);
		// Restart part-way through the next frame
		send_pixel(1'b1, 8'h80, 8'h01, 8'hFE);
		send_pixel(1'b0, 8'h7F, 8'hFF, 8'h00);
		send_pixel(1'b1, 8'hFF, 8'h00, 8'hFF);
		for (int i = 0; i < 8; i++)
			send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
		drain();

		// Random phases of small frames, mostly well formed
		while (items < RAND_ITEMS) begin
			pick = $urandom_range(9, 0);
			wr = (pick == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
			hr = (pick == 1) ? $urandom_range(2, 0) : $urandom_range(6, 3);
			w = eff_dim(wr, 1024);
			h = eff_dim(hr, 4096);
			set_config(11'(wr), 13'(hr), rand_kernel_row(), rand_kernel_row(),
				rand_kernel_row(), rand_divisor());
			nfr = $urandom_range(4, 1);
			for (int unsigned f = 0; f < nfr; f++) begin
				quiet = ($urandom_range(4, 0) == 0);
				if ($urandom_range(9, 0) == 0)
					rx_hold = 400;
				pick = $urandom_range(9, 0);
				if (pick == 0)
					send_frame($urandom_range(w * h - 1, 1), 1'b1);
				else
					send_frame(w * h, (f == 0) || (pick != 1));
			end
			drain();
		end

		// Tall frame, oversized height, identity kernel, with a long hold-off on the result side
		quiet = 1'b1;
		set_config(11'd3, 13'd8191, 48'd0, 48'd65536, 48'd0, 16'd1);
		rx_hold = 2000;
		send_frame(3 * 100, 1'b1);
		drain();

		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
